// File: hdl/lip_pkg.sv
// Shared constants, codes and a helper function of the interpolation weight engine.
`timescale 1ns / 1ps

package lip_pkg;

  localparam int MAX_POINTS = 256;
  localparam int FRAC_BITS  = 16;

  localparam int IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  localparam int VAL_W    = 32;
  localparam int OUT_IDX_W = 8;
  localparam int DEN_W    = VAL_W + 1;
  localparam int NUM_W    = DEN_W + FRAC_BITS;
  localparam int QUO_W    = NUM_W + 1;
  localparam int WIDE_W   = NUM_W + 2;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FEW       = 2'd1;
  localparam logic [1:0] ST_ZERO_SPAN = 2'd2;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = $signed({{(WIDE_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}});
    lo = $signed({{(WIDE_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}});
    if (v > hi) begin
      return hi[VAL_W-1:0];
    end else if (v < lo) begin
      return lo[VAL_W-1:0];
    end
    return v[VAL_W-1:0];
  endfunction

endpackage

// File: hdl/lip_if.sv
// Valid/ready channel interfaces for the input and result items.
`timescale 1ns / 1ps

interface lip_in_if;
  import lip_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic signed [VAL_W-1:0] point_value;

  modport source (output valid, output opcode, output point_value, input ready);
  modport sink (input valid, input opcode, input point_value, output ready);
endinterface

interface lip_out_if;
  import lip_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OUT_IDX_W-1:0]    lower_index;
  logic signed [VAL_W-1:0] upper_weight;
  logic signed [VAL_W-1:0] lower_weight;
  logic [1:0]              status;

  modport source (output valid, output lower_index, output upper_weight,
                  output lower_weight, output status, input ready);
  modport sink (input valid, input lower_index, input upper_weight,
                input lower_weight, input status, output ready);
endinterface

// File: hdl/lip_table_ram.sv
// Breakpoint table memory with one write port and one registered read port.
`timescale 1ns / 1ps

module lip_table_ram
  import lip_pkg::*;
(
  input  logic                    clk,
  input  logic                    we,
  input  logic [IDX_W-1:0]        waddr,
  input  logic signed [VAL_W-1:0] wdata,
  input  logic [IDX_W-1:0]        raddr,
  output logic signed [VAL_W-1:0] rdata
);

  logic signed [VAL_W-1:0] mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/lip_divider.sv
// Bit-serial signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module lip_divider
  import lip_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] dividend,
  input  logic signed [DEN_W-1:0] divisor,
  output logic                    done,
  output logic signed [QUO_W-1:0] quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0]     num_r;
  logic [DEN_W-1:0]     den_r;
  logic [DEN_W-1:0]     rem_r;
  logic                 neg_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] trial;
  logic             ge;

  always_comb begin
    rem_sh = {rem_r, num_r[NUM_W-1]};
    trial  = {1'b0, rem_sh} - {2'b00, den_r};
    ge     = ~trial[DEN_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= DIV_CNT_W'(NUM_W);
      num_r <= dividend[NUM_W-1] ? (~dividend + 1'b1) : dividend;
      den_r <= divisor[DEN_W-1] ? (~divisor + 1'b1) : divisor;
      rem_r <= '0;
      neg_r <= dividend[NUM_W-1] ^ divisor[DEN_W-1];
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      num_r <= {num_r[NUM_W-2:0], ge};
      rem_r <= ge ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed({1'b0, num_r}) : $signed({1'b0, num_r});

endmodule

// File: hdl/linear_interp_weight_engine.sv
// Top level: breakpoint table control, table scan, weight arithmetic and result register.
//
// Items arrive on in_ch (opcode, point_value) and results leave on out_ch, both
// valid/ready channels; an item moves at a clock edge where valid and ready are high.
// An append writes the next free table entry and gives no result; an append to a
// full table is dropped. A clear empties the table. A query with fewer than two
// points goes straight to the done state and answers with no scan. Otherwise the table
// is scanned one entry per cycle through the memory's read port, the two neighbors
// are read back, and a bit-serial divider produces one quotient bit per cycle.
// The length of a query is set by the scan length and, unless the span is zero,
// by the 49 divider steps.
// One item is worked on at a time; in_ch.ready is high only while the engine is idle.
// The result register frees the engine while a result waits: the next item is taken,
// and a finished query waits for the register only if the receiver still stalls.
// Reset (rst_n low, synchronous) empties the table and drops any held result; the
// table memory is not cleared, since entries are only read below the fill count.
`timescale 1ns / 1ps

module linear_interp_weight_engine
  import lip_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  lip_in_if.sink   in_ch,
  lip_out_if.source out_ch
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_RD_LO = 6'b000100,
    S_RD_HI = 6'b001000,
    S_DIV   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]        count_r;
  logic [IDX_W-1:0]        j_r, j_nxt;
  logic [IDX_W-1:0]        r_r, r_nxt;
  logic [IDX_W-1:0]        s_r, s_nxt;
  logic signed [VAL_W-1:0] pv_r;
  logic signed [VAL_W-1:0] xr_r;

  logic [OUT_IDX_W-1:0]    res_idx_r;
  logic signed [VAL_W-1:0] res_up_r;
  logic signed [VAL_W-1:0] res_lo_r;
  logic [1:0]              res_st_r;

  logic                    out_valid_r;
  logic [OUT_IDX_W-1:0]    out_idx_r;
  logic signed [VAL_W-1:0] out_up_r;
  logic signed [VAL_W-1:0] out_lo_r;
  logic [1:0]              out_st_r;

  logic                    in_acc;
  logic                    slot_free;
  logic                    ram_we;
  logic [IDX_W-1:0]        raddr;
  logic signed [VAL_W-1:0] rdata;
  logic                    scan_last;
  logic                    scan_stop;

  logic signed [DEN_W-1:0]  span;
  logic signed [DEN_W-1:0]  diff;
  logic                     div_start;
  logic                     div_done;
  logic signed [QUO_W-1:0]  mu;
  logic signed [WIDE_W-1:0] mu_wide;
  logic signed [WIDE_W-1:0] one_minus_mu;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && (state_r == S_IDLE);
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign ram_we      = in_acc && (in_ch.opcode == OP_APPEND) &&
                       (count_r < CNT_W'(MAX_POINTS));

  lip_table_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_ch.point_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign span = $signed({rdata[VAL_W-1], rdata}) - $signed({xr_r[VAL_W-1], xr_r});
  assign diff = $signed({pv_r[VAL_W-1], pv_r}) - $signed({xr_r[VAL_W-1], xr_r});
  assign div_start = (state_r == S_RD_HI) && (span != '0);

  lip_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ($signed({diff, {FRAC_BITS{1'b0}}})),
    .divisor  (span),
    .done     (div_done),
    .quotient (mu)
  );

  assign mu_wide      = WIDE_W'(mu);
  assign one_minus_mu = (WIDE_W'(1) <<< FRAC_BITS) - mu_wide;

  assign scan_last = (CNT_W'(j_r) + 1'b1) >= count_r;
  assign scan_stop = scan_last || !(pv_r > rdata);

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    r_nxt     = r_r;
    s_nxt     = s_r;
    raddr     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.opcode == OP_QUERY) begin
          state_nxt = (count_r < CNT_W'(2)) ? S_DONE : S_SCAN;
          j_nxt     = '0;
        end
      end
      S_SCAN: begin
        if (scan_stop) begin
          if (j_r == '0) begin
            r_nxt = '0;
            s_nxt = IDX_W'(1);
          end else begin
            r_nxt = j_r - 1'b1;
            s_nxt = j_r;
          end
          raddr     = r_nxt;
          state_nxt = S_RD_LO;
        end else begin
          j_nxt = j_r + 1'b1;
          raddr = j_nxt;
        end
      end
      S_RD_LO: begin
        raddr     = s_r;
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        state_nxt = (span == '0) ? S_DONE : S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        count_r <= count_r + 1'b1;
      end else if (in_acc && in_ch.opcode == OP_CLEAR) begin
        count_r <= '0;
      end
      if (state_r == S_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    j_r <= j_nxt;
    r_r <= r_nxt;
    s_r <= s_nxt;
    if (in_acc) begin
      pv_r <= in_ch.point_value;
    end
    if (state_r == S_RD_LO) begin
      xr_r <= rdata;
    end
    if (state_r == S_IDLE) begin
      res_idx_r <= '0;
      res_up_r  <= '0;
      res_lo_r  <= '0;
      res_st_r  <= ST_FEW;
    end else if (state_r == S_RD_HI) begin
      res_idx_r <= OUT_IDX_W'(r_r);
      res_up_r  <= '0;
      res_lo_r  <= '0;
      res_st_r  <= (span == '0) ? ST_ZERO_SPAN : ST_OK;
    end else if (state_r == S_DIV && div_done) begin
      res_up_r <= sat_val(mu_wide);
      res_lo_r <= sat_val(one_minus_mu);
    end
    if (state_r == S_DONE && slot_free) begin
      out_idx_r <= res_idx_r;
      out_up_r  <= res_up_r;
      out_lo_r  <= res_lo_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.lower_index  = out_idx_r;
  assign out_ch.upper_weight = out_up_r;
  assign out_ch.lower_weight = out_lo_r;
  assign out_ch.status       = out_st_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS))
    else $error("Fill count exceeds the table size.");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CNT_W'(j_r) < count_r && count_r >= CNT_W'(2)))
    else $error("Scan reads beyond the filled part of the table.");

  a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (count_r == $past(count_r) + 1'b1))
    else $error("Accepted append did not advance the fill count.");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("Divider finished outside the divide state.");

  a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ch.ready) |=> (state_r == S_DONE))
    else $error("Finished query left the done state while the result register was full.");

endmodule
